// ----- src/route_table_longest_prefix_match_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Route table LPM unit - assertion macros
// Shared assertion forms for the route table RTL. Both need clk and rst in
// scope at the place of use.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH
`define ROUTE_TABLE_LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, off while in reset
`define RTLPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define RTLPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rtlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Route table LPM package
// Word types for the request and response channels, the stored route and
// the action and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rtlpm_pkg;

  // Action codes
  localparam logic [2:0] ACT_INSTALL = 3'd0;
  localparam logic [2:0] ACT_DELETE  = 3'd1;
  localparam logic [2:0] ACT_UPDATE  = 3'd2;
  localparam logic [2:0] ACT_EXACT   = 3'd3;
  localparam logic [2:0] ACT_LPM     = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Longest legal prefix length; larger lengths saturate to it
  localparam logic [5:0] MAX_LEN = 6'd32;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] key_prefix;
    logic [5:0]  key_len;
    logic [23:0] route_cost;
    logic [1:0]  route_level;
    logic [15:0] route_version;
    logic [15:0] nexthop_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_default;
    logic [31:0] hit_prefix;
    logic [5:0]  hit_len;
    logic [23:0] hit_cost;
    logic [1:0]  hit_level;
    logic [15:0] hit_version;
    logic [15:0] hit_handle;
  } rsp_t;

  // One stored route
  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic [23:0] cost;
    logic [1:0]  level;
    logic [15:0] version;
    logic [15:0] handle;
  } route_t;

  // One table slot as held in RAM
  typedef struct packed {
    logic   valid;
    route_t route;
  } slot_t;

endpackage

`default_nettype wire

// ----- src/rtlpm_if.sv -----
// ----------------------------------------------------------------------------
// Route table LPM channel interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtlpm_req_if;
  logic              valid;
  logic              ready;
  rtlpm_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtlpm_rsp_if;
  logic              valid;
  logic              ready;
  rtlpm_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/rtlpm_ram.sv -----
// ----------------------------------------------------------------------------
// Route table LPM generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/route_table_longest_prefix_match_unit.sv -----
// ----------------------------------------------------------------------------
// Route table longest prefix match unit
// IPv4 route table of TABLE_DEPTH slots with install, delete, update, exact
// lookup and longest prefix lookup, one response word per request word.
// ----------------------------------------------------------------------------
// Every request walks the whole table through one RAM read port and one
// compare unit, one slot per cycle. The next request is accepted only after
// the scan, the write-back of the found slot by install, delete or update,
// and the reply step. The reply step also waits for the output register to
// be free, so a word still held there stalls it. After reset a clearing
// pass marks every slot free; no request is taken meanwhile. A finished
// response sits in an output register until taken; the next request may be
// accepted meanwhile.
`default_nettype none

`include "route_table_longest_prefix_match_unit_defines.svh"

module route_table_longest_prefix_match_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  rtlpm_req_if.sink          req,
  rtlpm_rsp_if.source        rsp
);
  import rtlpm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = $bits(slot_t);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_REPLY = 5'b10000
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic            chk_vld;
  logic [AW-1:0]   chk_idx;
  logic            found;
  logic            dflt_found;
  logic [5:0]      best_len;
  logic [AW-1:0]   idx;
  route_t          hit;
  route_t          dflt;
  req_t            req_q;
  logic            rsp_valid;
  rsp_t            rsp_data;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  slot_t           ram_wdata;
  logic [SW-1:0]   ram_rdata;
  slot_t           slot;
  route_t          req_route;
  rsp_t            rsp_next;
  req_t            req_sat;
  logic            reply_fire;

  logic [31:0]     len_mask;
  logic            exact_hit;
  logic            is_dflt;
  logic            lpm_hit;
  logic            writes_back;

  // Slot storage
  rtlpm_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign slot = slot_t'(ram_rdata);

  // Incoming word with the prefix length saturated
  always_comb begin
    req_sat = req.data;
    if (req.data.key_len > MAX_LEN) begin
      req_sat.key_len = MAX_LEN;
    end
  end

  // Route carried by the request
  assign req_route = '{
    prefix:  req_q.key_prefix,
    len:     req_q.key_len,
    cost:    req_q.route_cost,
    level:   req_q.route_level,
    version: req_q.route_version,
    handle:  req_q.nexthop_handle
  };

  // Shared compare unit on the slot just read
  assign len_mask  = (slot.route.len == 6'd0) ? 32'd0
                   : (32'hFFFF_FFFF << (MAX_LEN - slot.route.len));
  assign exact_hit = slot.valid && (slot.route.prefix == req_q.key_prefix)
                     && (slot.route.len == req_q.key_len);
  assign is_dflt   = slot.valid && (slot.route.prefix == 32'd0)
                     && (slot.route.len == 6'd0);
  assign lpm_hit   = slot.valid && !is_dflt
                     && ((req_q.key_prefix & len_mask) == slot.route.prefix)
                     && (slot.route.len > best_len);

  always_comb begin
    writes_back = found && (req_q.action inside {ACT_INSTALL, ACT_DELETE, ACT_UPDATE});
  end

  // Reply step may load the output register this cycle
  assign reply_fire = (state == ST_REPLY) && (!rsp_valid || rsp.ready);

  // RAM write: clearing pass or write-back of the chosen slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
      end
      ST_WRITE: begin
        ram_we          = 1'b1;
        ram_wdata.valid = (req_q.action != ACT_DELETE);
        ram_wdata.route = (req_q.action == ACT_DELETE) ? hit : req_route;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Response word
  always_comb begin
    rsp_next        = '0;
    rsp_next.status = ST_NOT_FOUND;
    case (req_q.action)
      ACT_INSTALL: begin
        if (found) begin
          rsp_next.status = ST_OK;
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      ACT_DELETE, ACT_EXACT, ACT_UPDATE: begin
        if (found) begin
          rsp_next.status = ST_OK;
        end
      end
      ACT_LPM: begin
        if (found || dflt_found) begin
          rsp_next.status     = ST_OK;
          rsp_next.is_default = !found;
        end
      end
      default: begin
        rsp_next.status = ST_NOT_FOUND;
      end
    endcase
    if (rsp_next.status == ST_OK) begin
      if (req_q.action == ACT_INSTALL || req_q.action == ACT_UPDATE) begin
        {rsp_next.hit_prefix, rsp_next.hit_len, rsp_next.hit_cost,
         rsp_next.hit_level, rsp_next.hit_version, rsp_next.hit_handle} = req_route;
      end else if (rsp_next.is_default) begin
        {rsp_next.hit_prefix, rsp_next.hit_len, rsp_next.hit_cost,
         rsp_next.hit_level, rsp_next.hit_version, rsp_next.hit_handle} = dflt;
      end else begin
        {rsp_next.hit_prefix, rsp_next.hit_len, rsp_next.hit_cost,
         rsp_next.hit_level, rsp_next.hit_version, rsp_next.hit_handle} = hit;
      end
    end
  end

  // Sequencer and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      chk_vld    <= 1'b0;
      found      <= 1'b0;
      dflt_found <= 1'b0;
      best_len   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // output register: load on reply, clear when taken
      if (reply_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (cnt == CW'(TABLE_DEPTH - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            req_q            <= req_sat;
            cnt              <= '0;
            found            <= 1'b0;
            dflt_found       <= 1'b0;
            best_len         <= '0;
            state            <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue reads slot by slot
          if (cnt < CW'(TABLE_DEPTH)) begin
            cnt     <= cnt + 1'b1;
            chk_vld <= 1'b1;
            chk_idx <= cnt[AW-1:0];
          end else begin
            chk_vld <= 1'b0;
            if (!chk_vld) begin
              state <= writes_back ? ST_WRITE : ST_REPLY;
            end
          end
          // check the slot read in the last cycle
          if (chk_vld) begin
            case (req_q.action)
              ACT_INSTALL: begin
                if (!slot.valid && !found) begin
                  found <= 1'b1;
                  idx   <= chk_idx;
                end
              end
              ACT_DELETE, ACT_UPDATE, ACT_EXACT: begin
                if (exact_hit && !found) begin
                  found <= 1'b1;
                  idx   <= chk_idx;
                  hit   <= slot.route;
                end
              end
              ACT_LPM: begin
                if (is_dflt) begin
                  dflt_found <= 1'b1;
                  dflt       <= slot.route;
                end
                if (lpm_hit) begin
                  found    <= 1'b1;
                  best_len <= slot.route.len;
                  hit      <= slot.route;
                end
              end
              default: begin
                found <= found;
              end
            endcase
          end
        end
        ST_WRITE: begin
          state <= ST_REPLY;
        end
        ST_REPLY: begin
          if (reply_fire) begin
            rsp_data  <= rsp_next;
            cnt       <= '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Checks
  `RTLPM_ASSERT_NEXT(a_accept_starts_scan, req.valid && req.ready, state == ST_SCAN,
    "accepted word did not start a table scan")
  `RTLPM_ASSERT_IMP(a_rsp_from_reply, $rose(rsp.valid), $past(state == ST_REPLY),
    "response appeared outside the reply step")
  `RTLPM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= CW'(TABLE_DEPTH),
    "scan counter ran past the table")
  `RTLPM_ASSERT_IMP(a_default_ok, rsp.valid && rsp.data.is_default,
    rsp.data.status == ST_OK, "default route flagged without a hit")
  `RTLPM_ASSERT_IMP(a_no_accept_in_clear, state == ST_CLEAR, !req.ready,
    "request taken during the clearing pass")

endmodule

`default_nettype wire
